>>> rtl/bcv_pkg.sv
// Shared types and constants for the bitmap corner vertex detector.
package bcv_pkg;

  localparam int CFG_W   = 13;
  localparam int COORD_W = 12;
  localparam int TOTAL_W = 24;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Configuration register indexes.
  localparam logic [1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_IDX_LAND   = 2'd2;

  // Land counts in a 2x2 window that mark a vertex.
  localparam logic [2:0] LAND_CONVEX  = 3'd1;
  localparam logic [2:0] LAND_CONCAVE = 3'd3;

  // Per-pixel flags handed from the scan stage to the classifier.
  typedef struct packed {
    logic cur;          // pixel is land
    logic win;          // pixel closes a reportable window
    logic first;        // first pixel of a frame
    logic frame_end;    // last pixel of a frame
  } pix_info_t;

endpackage

>>> rtl/bcv_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bcv_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

endmodule

>>> rtl/bcv_scan.sv
// Raster position tracking, line store read issue and the first pipeline stage.
module bcv_scan
  import bcv_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             in_pixel,
  input  logic [CFG_W-1:0] cfg_width,
  input  logic [CFG_W-1:0] cfg_height,
  input  logic             land_value,
  input  logic             s1_take,
  output logic             rd_en,
  output logic [CW-1:0]    rd_addr,
  output logic             s1_valid_r,
  output pix_info_t        s1_info_r,
  output logic [CW-1:0]    s1_col_r,
  output logic [RW-1:0]    s1_row_r
);

  localparam int WCW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int HCW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic           s1_valid_nxt;
  logic [WCW-1:0] w_eff, col_p1;
  logic [HCW-1:0] h_eff, row_p1;
  logic           last_col, last_row, accept;
  pix_info_t      info;

  // Effective frame size, clamped to 2..MAX.
  always_comb begin
    if (WCW'(cfg_width) < WCW'(2)) begin
      w_eff = WCW'(2);
    end else if (WCW'(cfg_width) > WCW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(cfg_width);
    end
    if (HCW'(cfg_height) < HCW'(2)) begin
      h_eff = HCW'(2);
    end else if (HCW'(cfg_height) > HCW'(MAX_HEIGHT)) begin
      h_eff = HCW'(MAX_HEIGHT);
    end else begin
      h_eff = HCW'(cfg_height);
    end
  end

  assign col_p1    = WCW'(col_r) + WCW'(1);
  assign row_p1    = HCW'(row_r) + HCW'(1);
  assign last_col  = col_p1 >= w_eff;
  assign last_row  = row_p1 >= h_eff;
  assign in_tready = !s1_valid_r || s1_take;
  assign accept    = in_tvalid && in_tready;

  // The above pixel is fetched at the transfer and arrives with the stage-one item.
  assign rd_en   = accept;
  assign rd_addr = col_r;

  always_comb begin
    info.cur       = (in_pixel == land_value);
    info.first     = (col_r == '0) && (row_r == '0);
    info.win       = (col_r != '0) && (row_r != '0) &&
                     (WCW'(col_r) < w_eff) && (HCW'(row_r) < h_eff);
    info.frame_end = last_col && last_row;

    col_nxt      = col_r;
    row_nxt      = row_r;
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r <= info;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
    end
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < MAX_WIDTH)
    else $error("column counter beyond line store depth");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(row_r) < MAX_HEIGHT)
    else $error("row counter beyond maximum height");

endmodule

>>> rtl/bcv_class.sv
// Window classification, line store write-back, running totals and output register.
module bcv_class
  import bcv_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s1_valid,
  input  pix_info_t          s1_info,
  input  logic [CW-1:0]      s1_col,
  input  logic [RW-1:0]      s1_row,
  input  logic               above,
  output logic               s1_take,
  output logic               wr_en,
  output logic [CW-1:0]      wr_addr,
  output logic               wr_data,
  input  logic               out_tready,
  output logic               out_valid_r,
  output logic               found_r,
  output logic               kind_r,
  output logic [COORD_W-1:0] vcol_r,
  output logic [COORD_W-1:0] vrow_r,
  output logic               frame_done_r,
  output logic [TOTAL_W-1:0] concave_r,
  output logic [TOTAL_W-1:0] convex_r
);

  logic               adv;
  logic               left_r, left_nxt;
  logic               above_left_r, above_left_nxt;
  logic               out_valid_nxt;
  logic [TOTAL_W-1:0] concave_nxt, convex_nxt, concave_base, convex_base;
  logic [2:0]         land;
  logic               concave_hit, convex_hit, found;
  logic [31:0]        col_wide, row_wide;

  assign s1_take = !out_valid_r || out_tready;
  assign adv     = s1_valid && s1_take;

  // Each column is written one row before it is read again, never in the same cycle.
  assign wr_en   = adv;
  assign wr_addr = s1_col;
  assign wr_data = s1_info.cur;

  assign land = 3'(above_left_r) + 3'(above) + 3'(left_r) + 3'(s1_info.cur);
  assign concave_hit = s1_info.win && (land == LAND_CONCAVE);
  assign convex_hit  = s1_info.win && (land == LAND_CONVEX);
  assign found       = concave_hit || convex_hit;
  assign col_wide    = 32'(s1_col) - 32'd1;
  assign row_wide    = 32'(s1_row) - 32'd1;

  always_comb begin
    concave_base = s1_info.first ? '0 : concave_r;
    convex_base  = s1_info.first ? '0 : convex_r;
    concave_nxt  = concave_r;
    convex_nxt   = convex_r;
    left_nxt       = left_r;
    above_left_nxt = above_left_r;
    out_valid_nxt  = out_valid_r;
    if (adv) begin
      concave_nxt = (concave_hit && concave_base != TOTAL_MAX) ?
                    concave_base + TOTAL_W'(1) : concave_base;
      convex_nxt  = (convex_hit && convex_base != TOTAL_MAX) ?
                    convex_base + TOTAL_W'(1) : convex_base;
      left_nxt       = s1_info.cur;
      above_left_nxt = above;
      out_valid_nxt  = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      concave_r    <= '0;
      convex_r     <= '0;
      left_r       <= 1'b0;
      above_left_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      concave_r    <= concave_nxt;
      convex_r     <= convex_nxt;
      left_r       <= left_nxt;
      above_left_r <= above_left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      found_r      <= found;
      kind_r       <= concave_hit;
      vcol_r       <= found ? col_wide[COORD_W-1:0] : '0;
      vrow_r       <= found ? row_wide[COORD_W-1:0] : '0;
      frame_done_r <= s1_info.frame_end;
    end
  end

  a_quiet_when_no_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !found_r |-> !kind_r && vcol_r == '0 && vrow_r == '0)
    else $error("vertex fields set without a vertex");

  a_vertex_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && found_r |-> (kind_r ? concave_r != '0 : convex_r != '0))
    else $error("reported vertex missing from its total");

endmodule

>>> rtl/bitmap_corner_vertex_detector.sv
// Two-stage pipeline: stage-one registers, then the output register. Throughput is one pixel
// per cycle unless the output stalls, bounded by one line store read and one write per pixel.
// The line store is a single RAM of MAX_WIDTH one-bit entries, read at transfer, written back
// one stage later; the previous row's bit for a column is always written before it is read.
// Synchronous active-low reset clears counters, totals and neighbor bits and restores the
// configuration defaults; the line store is not cleared, so items are taken right after reset.
module bitmap_corner_vertex_detector
  import bcv_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,    // [0] pixel
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [71:0]      out_tdata,   // [11:0] vertex_col, [23:12] vertex_row,
                                        // [47:24] concave_total, [71:48] convex_total
  output logic [1:0]       out_tuser,   // [0] vertex_found, [1] vertex_kind
  output logic             out_tlast,   // frame_done
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CFG_W-1:0]   cfg_width_r, cfg_height_r;
  logic               land_value_r;
  logic               s1_take, rd_en, s1_valid, above;
  logic [CW-1:0]      rd_addr, s1_col, wr_addr;
  logic [RW-1:0]      s1_row;
  pix_info_t          s1_info;
  logic               wr_en, wr_data;
  logic               found, kind, frame_done;
  logic [COORD_W-1:0] vcol, vrow;
  logic [TOTAL_W-1:0] concave, convex;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= CFG_W'(4096);
      cfg_height_r <= CFG_W'(4096);
      land_value_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IDX_WIDTH:  cfg_width_r  <= cfg_wdata;
        CFG_IDX_HEIGHT: cfg_height_r <= cfg_wdata;
        CFG_IDX_LAND:   land_value_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  bcv_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_pixel   (in_tdata[0]),
    .cfg_width  (cfg_width_r),
    .cfg_height (cfg_height_r),
    .land_value (land_value_r),
    .s1_take    (s1_take),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .s1_valid_r (s1_valid),
    .s1_info_r  (s1_info),
    .s1_col_r   (s1_col),
    .s1_row_r   (s1_row)
  );

  bcv_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk       (clk),
    .we        (wr_en),
    .waddr     (wr_addr),
    .wdata     (wr_data),
    .re        (rd_en),
    .raddr     (rd_addr),
    .rd_data_r (above)
  );

  bcv_class #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_class (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1_valid     (s1_valid),
    .s1_info      (s1_info),
    .s1_col       (s1_col),
    .s1_row       (s1_row),
    .above        (above),
    .s1_take      (s1_take),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .out_tready   (out_tready),
    .out_valid_r  (out_tvalid),
    .found_r      (found),
    .kind_r       (kind),
    .vcol_r       (vcol),
    .vrow_r       (vrow),
    .frame_done_r (frame_done),
    .concave_r    (concave),
    .convex_r     (convex)
  );

  assign out_tdata = {convex, concave, vrow, vcol};
  assign out_tuser = {kind, found};
  assign out_tlast = frame_done;

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && rd_en |-> wr_addr != rd_addr)
    else $error("line store read and write hit the same column");

endmodule
